@@ rtl/pfbrp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbrp_pkg
// Shared types and constants of the per-flow byte rate policer.
// ----------------------------------------------------------------------------
package pfbrp_pkg;

  localparam int unsigned TableSlots = 4096;
  localparam int unsigned SlotW      = $clog2(TableSlots);

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 31;
  localparam int unsigned ThrW     = 31;
  localparam int unsigned RateW    = 31;
  localparam int unsigned MsW      = 10;

  localparam logic [ThrW-1:0]  ThrReset  = ThrW'(1048576);
  localparam logic [RateW-1:0] RateReset = RateW'(2000);
  localparam logic [MsW-1:0]   MsReset   = MsW'(1);

  // input word: src_addr, dst_addr, src_port, dst_port, total_length,
  // ip_header_words, tcp_header_words, now_tick
  localparam int unsigned InDataW  = 152;
  // output word: accept, flow_slot, flow_created, flow_accepted_bytes,
  // flow_dropped_bytes, zero fill
  localparam int unsigned OutDataW = 80;
  localparam int unsigned FlowSlotW = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 2'd0,
    CfgRate      = 2'd1,
    CfgMsPerTick = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] acc_pkts;
    logic [31:0] drop_pkts;
    logic [31:0] acc_bytes;
    logic [31:0] drop_bytes;
    logic [31:0] last_tick;
    logic [31:0] limit;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

@@ rtl/pfbrp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbrp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pfbrp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/per_flow_byte_rate_policer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_flow_byte_rate_policer
// Per-flow token bucket policer over a hashed flow table.
//
// Input stream carries one packet header summary per word; tuser is is_tcp,
// tlast is the TCP FIN bit. Output stream returns one verdict word per input
// word, in order. The user writes configuration registers through cfg_we_i,
// cfg_idx_i and cfg_data_i while the block is idle, which it does not enforce.
//
// A non-TCP word is answered in the cycle after acceptance. A TCP word
// passes through hash, table read, entry merge and first refill product,
// second refill product, and decision and write back, which waits while the
// output is stalled. The flow table is one RAM with a single read-modify-write
// in flight, so words are handled one at a time.
//
// After reset the table is swept to invalid with tready low.
// When the receiver stalls the verdict waits in the output register and the
// next word is taken only once that register is free or being drained.
// ----------------------------------------------------------------------------
module per_flow_byte_rate_policer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pfbrp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pfbrp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // src_addr, dst_addr, src_port, dst_port, total_length,
  // ip_header_words, tcp_header_words, now_tick
  input  logic [pfbrp_pkg::InDataW-1:0]    s_axis_tdata_i,
  // is_tcp
  input  logic                             s_axis_tuser_i,
  input  logic                             s_axis_tlast_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // accept, flow_slot, flow_created, flow_accepted_bytes,
  // flow_dropped_bytes, zero fill
  output logic [pfbrp_pkg::OutDataW-1:0]   m_axis_tdata_o
);

  import pfbrp_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CALC,
    S_MUL,
    S_UPD
  } state_e;

  state_e             state_q;
  logic [SlotW-1:0]   clr_cnt_q;
  logic [ThrW-1:0]    thr_q;
  logic [RateW-1:0]   rate_q;
  logic [MsW-1:0]     ms_q;

  logic [SlotW-1:0]   hash_a_q;
  logic [SlotW-1:0]   hash_b_q;
  logic [SlotW-1:0]   slot_q;
  logic [15:0]        payload_q;
  logic               fin_q;
  logic [31:0]        now_q;
  entry_t             ent_q;
  logic               created_q;
  logic               refill_q;
  logic [31:0]        mul_q;

  logic               out_valid_q;
  logic               out_accept_q;
  logic [FlowSlotW-1:0] out_slot_q;
  logic               out_created_q;
  logic [31:0]        out_acc_q;
  logic [31:0]        out_drop_q;

  // input fields
  logic [31:0]        in_src_addr;
  logic [31:0]        in_dst_addr;
  logic [15:0]        in_src_port;
  logic [15:0]        in_dst_port;
  logic [15:0]        in_total_len;
  logic [3:0]         in_ip_hw;
  logic [3:0]         in_tcp_hw;
  logic [31:0]        in_now;

  assign in_src_addr  = s_axis_tdata_i[31:0];
  assign in_dst_addr  = s_axis_tdata_i[63:32];
  assign in_src_port  = s_axis_tdata_i[79:64];
  assign in_dst_port  = s_axis_tdata_i[95:80];
  assign in_total_len = s_axis_tdata_i[111:96];
  assign in_ip_hw     = s_axis_tdata_i[115:112];
  assign in_tcp_hw    = s_axis_tdata_i[119:116];
  assign in_now       = s_axis_tdata_i[151:120];

  logic s_acc;
  logic out_free;
  logic out_valid_d;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if ((s_acc && !s_axis_tuser_i) || (state_q == S_UPD && out_free)) begin
      out_valid_d = 1'b1;
    end
  end

  // residue products, low slot bits only
  logic [SlotW-1:0] sa_p1, da_p1, sp_p1, dp_p1;
  logic [SlotW-1:0] prod_a, prod_b, slot_d;

  assign sa_p1  = in_src_addr[SlotW-1:0] + SlotW'(1);
  assign da_p1  = in_dst_addr[SlotW-1:0] + SlotW'(1);
  assign sp_p1  = in_src_port[SlotW-1:0] + SlotW'(1);
  assign dp_p1  = in_dst_port[SlotW-1:0] + SlotW'(1);
  assign prod_a = sa_p1 * da_p1;
  assign prod_b = sp_p1 * dp_p1;
  assign slot_d = hash_a_q * hash_b_q;

  // payload length, bit 17 flags a negative result
  logic [17:0] plen;
  logic [15:0] payload_d;

  assign plen      = {2'b00, in_total_len} - {12'd0, in_ip_hw, 2'b00}
                     - {12'd0, in_tcp_hw, 2'b00};
  assign payload_d = plen[17] ? 16'd0 : plen[15:0];

  // table
  logic              ram_we;
  logic [SlotW-1:0]  ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic              ram_re;
  logic [EntryW-1:0] ram_rdata;

  pfbrp_ram #(
    .Width (EntryW),
    .Depth (TableSlots)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  // entry merge and refill product
  entry_t      rd_ent;
  entry_t      cur_ent;
  logic        created_d;
  logic [31:0] elapsed;
  logic [31:0] tick_diff;
  logic        refill_d;
  logic [31:0] mul1_d;

  always_comb begin
    rd_ent    = entry_t'(ram_rdata);
    created_d = !rd_ent.valid;
    cur_ent   = rd_ent;
    if (created_d) begin
      cur_ent       = '0;
      cur_ent.valid = 1'b1;
      cur_ent.limit = {1'b0, thr_q};
    end
    tick_diff = cur_ent.last_tick - now_q;
    elapsed   = (cur_ent.last_tick == 32'd0) ? 32'd0 : (now_q - cur_ent.last_tick);
    refill_d  = (payload_q != 16'd0) && (cur_ent.acc_bytes > {1'b0, thr_q})
                && tick_diff[31];
    mul1_d    = elapsed * {1'b0, rate_q};
  end

  // decision and write back
  entry_t      upd_ent;
  logic        pass;
  logic [31:0] new_limit;

  always_comb begin
    upd_ent   = ent_q;
    new_limit = ent_q.limit + (refill_q ? mul_q : 32'd0);
    pass      = 1'b1;
    if (payload_q != 16'd0) begin
      upd_ent.limit = new_limit;
      if (refill_q) begin
        upd_ent.last_tick = now_q;
      end
      pass = (ent_q.acc_bytes < {1'b0, thr_q}) || (ent_q.acc_bytes < new_limit);
      if (pass) begin
        upd_ent.acc_pkts  = ent_q.acc_pkts + 32'd1;
        upd_ent.acc_bytes = ent_q.acc_bytes + {16'd0, payload_q};
      end else begin
        upd_ent.drop_pkts  = ent_q.drop_pkts + 32'd1;
        upd_ent.drop_bytes = ent_q.drop_bytes + {16'd0, payload_q};
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = '0;
    ram_re    = (state_q == S_READ);
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
    end else if (state_q == S_UPD && out_free) begin
      ram_we          = 1'b1;
      ram_wdata       = upd_ent;
      ram_wdata[EntryW-1] = !fin_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_cnt_q     <= '0;
      thr_q         <= ThrReset;
      rate_q        <= RateReset;
      ms_q          <= MsReset;
      hash_a_q      <= '0;
      hash_b_q      <= '0;
      slot_q        <= '0;
      payload_q     <= '0;
      fin_q         <= 1'b0;
      now_q         <= '0;
      ent_q         <= '0;
      created_q     <= 1'b0;
      refill_q      <= 1'b0;
      mul_q         <= '0;
      out_valid_q   <= 1'b0;
      out_accept_q  <= 1'b0;
      out_slot_q    <= '0;
      out_created_q <= 1'b0;
      out_acc_q     <= '0;
      out_drop_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgThreshold: thr_q  <= cfg_data_i[ThrW-1:0];
          CfgRate:      rate_q <= cfg_data_i[RateW-1:0];
          CfgMsPerTick: ms_q   <= cfg_data_i[MsW-1:0];
          default: ;
        endcase
      end

      out_valid_q <= out_valid_d;

      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + SlotW'(1);
          if (clr_cnt_q == SlotW'(TableSlots - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_acc) begin
            hash_a_q  <= prod_a;
            hash_b_q  <= prod_b;
            payload_q <= payload_d;
            fin_q     <= s_axis_tlast_i;
            now_q     <= in_now;
            if (s_axis_tuser_i) begin
              state_q <= S_HASH;
            end else begin
              out_accept_q  <= 1'b1;
              out_slot_q    <= '0;
              out_created_q <= 1'b0;
              out_acc_q     <= '0;
              out_drop_q    <= '0;
            end
          end
        end
        S_HASH: begin
          slot_q  <= slot_d;
          state_q <= S_READ;
        end
        S_READ: begin
          state_q <= S_CALC;
        end
        S_CALC: begin
          ent_q     <= cur_ent;
          created_q <= created_d;
          refill_q  <= refill_d;
          mul_q     <= mul1_d;
          state_q   <= S_MUL;
        end
        S_MUL: begin
          mul_q   <= mul_q * {22'd0, ms_q};
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (out_free) begin
            out_accept_q  <= pass;
            out_slot_q    <= slot_q;
            out_created_q <= created_q;
            out_acc_q     <= upd_ent.acc_bytes;
            out_drop_q    <= upd_ent.drop_bytes;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_drop_q, out_acc_q, out_created_q, out_slot_q,
                            out_accept_q};

endmodule

@@ rtl/pfbrp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbrp_checker
// Port-level checks of the per-flow byte rate policer, bound to the top.
// ----------------------------------------------------------------------------
module pfbrp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             s_axis_tuser_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [pfbrp_pkg::OutDataW-1:0]   m_axis_tdata_o
);

  import pfbrp_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  // table sweep after reset blocks input
  a_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready_o)
    else $error("input taken during table sweep");

  // input only taken when the output register can take its result
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |-> !m_axis_tvalid_o || m_axis_tready_i)
    else $error("input taken with output blocked");

  // non-tcp verdict next cycle, accepted at slot zero
  a_non_tcp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !s_axis_tuser_i |=> m_axis_tvalid_o && m_axis_tdata_o[0]
      && (m_axis_tdata_o[FlowSlotW:1] == '0))
    else $error("non-tcp verdict wrong");

  // tcp word needs the table, no verdict next cycle
  a_tcp_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser_i |=> !m_axis_tvalid_o)
    else $error("tcp verdict too early");

endmodule

bind per_flow_byte_rate_policer pfbrp_checker u_pfbrp_checker (.*);

@@ test/per_flow_byte_rate_policer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_flow_byte_rate_policer_tb
// Self-checking bench for the per-flow byte rate policer.
//
// A short directed list of header words and register writes runs first:
// non-TCP words, zero and negative payloads, FIN teardown and re-creation,
// the first refill, time going backward and far ahead, and the register
// extremes. Random traffic follows in several register phases, each over a
// small pool of flows in which half the tuples collide with the other half.
// Every accepted header word goes through a behavioral flow table, and each
// verdict word is compared field by field with the oldest prediction. Both
// stream sides idle at random; once the output holds off for a long stretch
// and once the input waits for the pipeline to drain.
// ----------------------------------------------------------------------------
module per_flow_byte_rate_policer_tb;
  import pfbrp_pkg::*;

  localparam int unsigned PhaseWords = 85;
  localparam int unsigned PoolSize   = 8;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainPad   = 10;
  localparam int unsigned MaxPrinted = 40;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef struct {
    logic        is_tcp;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] total_length;
    logic [3:0]  ip_hdr_words;
    logic [3:0]  tcp_hdr_words;
    logic        fin;
    logic [31:0] now_tick;
  } hdr_t;

  typedef struct {
    logic                 accept;
    logic [FlowSlotW-1:0] slot;
    logic                 created;
    logic [31:0]          acc_bytes;
    logic [31:0]          drop_bytes;
  } verdict_t;

  typedef struct {
    bit          valid;
    logic [31:0] acc_pkts;
    logic [31:0] drop_pkts;
    logic [31:0] acc_bytes;
    logic [31:0] drop_bytes;
    logic [31:0] last_tick;
    logic [31:0] limit;
  } flow_t;

  typedef enum logic {
    RowHeader,
    RowRegWrite
  } row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  val;
    hdr_t                 hdr;
    bit                   typed;
    verdict_t             want;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_idx;
  logic [CfgDataW-1:0]  cfg_data;
  logic                 s_valid;
  logic                 s_ready;
  logic [InDataW-1:0]   s_data;
  logic                 s_tcp;
  logic                 s_fin;
  logic                 m_valid;
  logic                 m_ready;
  logic [OutDataW-1:0]  m_data;

  flow_t       flow_tab [TableSlots];
  logic [31:0] thr_reg;
  logic [31:0] rate_reg;
  logic [31:0] ms_reg;
  verdict_t    verdict_q [$];
  dir_row_t    dir_rows [$];

  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;
  int mismatch_count   = 0;
  int result_count     = 0;
  int sent_count       = 0;
  int tcp_count        = 0;
  int dropped_verdicts = 0;
  int create_count     = 0;

  always #2 clk_i = ~clk_i;

  per_flow_byte_rate_policer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_tcp),
    .s_axis_tlast_i  (s_fin),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  function automatic logic [SlotW-1:0] flow_slot_of(logic [31:0] sa, logic [31:0] da,
                                                    logic [15:0] sp, logic [15:0] dp);
    logic [31:0] p;
    p = 32'(sa[SlotW-1:0]) + 32'd1;
    p = p * (32'(da[SlotW-1:0]) + 32'd1);
    p = p * (32'(sp[SlotW-1:0]) + 32'd1);
    p = p * (32'(dp[SlotW-1:0]) + 32'd1);
    return p[SlotW-1:0];
  endfunction

  function automatic verdict_t police_header(hdr_t h);
    verdict_t         v;
    logic [SlotW-1:0] s;
    logic [31:0]      pay;
    logic [31:0]      lag;
    int               plen;
    v.accept     = 1'b1;
    v.slot       = '0;
    v.created    = 1'b0;
    v.acc_bytes  = '0;
    v.drop_bytes = '0;
    if (!h.is_tcp) return v;
    s = flow_slot_of(h.src_addr, h.dst_addr, h.src_port, h.dst_port);
    if (!flow_tab[s].valid) begin
      flow_tab[s].valid      = 1'b1;
      flow_tab[s].acc_pkts   = '0;
      flow_tab[s].drop_pkts  = '0;
      flow_tab[s].acc_bytes  = '0;
      flow_tab[s].drop_bytes = '0;
      flow_tab[s].last_tick  = '0;
      flow_tab[s].limit      = thr_reg;
      v.created = 1'b1;
    end
    plen = int'(h.total_length) - 4 * int'(h.ip_hdr_words) - 4 * int'(h.tcp_hdr_words);
    pay  = (plen > 0) ? 32'(plen) : 32'd0;
    if (pay != 0) begin
      lag = flow_tab[s].last_tick - h.now_tick;
      if (flow_tab[s].acc_bytes > thr_reg && lag[31]) begin
        if (flow_tab[s].last_tick == 0) flow_tab[s].last_tick = h.now_tick;
        flow_tab[s].limit = flow_tab[s].limit
                          + (h.now_tick - flow_tab[s].last_tick) * rate_reg * ms_reg;
        flow_tab[s].last_tick = h.now_tick;
      end
      if (flow_tab[s].acc_bytes < thr_reg || flow_tab[s].acc_bytes < flow_tab[s].limit) begin
        flow_tab[s].acc_pkts  = flow_tab[s].acc_pkts + 32'd1;
        flow_tab[s].acc_bytes = flow_tab[s].acc_bytes + pay;
      end else begin
        flow_tab[s].drop_pkts  = flow_tab[s].drop_pkts + 32'd1;
        flow_tab[s].drop_bytes = flow_tab[s].drop_bytes + pay;
        v.accept = 1'b0;
      end
    end
    v.slot       = FlowSlotW'(s);
    v.acc_bytes  = flow_tab[s].acc_bytes;
    v.drop_bytes = flow_tab[s].drop_bytes;
    if (h.fin) flow_tab[s].valid = 1'b0;
    return v;
  endfunction

  function automatic hdr_t mk_hdr(logic tcp, logic [31:0] sa, logic [31:0] da,
                                  logic [15:0] sp, logic [15:0] dp, logic [15:0] tot,
                                  logic [3:0] ihl, logic [3:0] doff, logic fin,
                                  logic [31:0] now);
    hdr_t h;
    h.is_tcp        = tcp;
    h.src_addr      = sa;
    h.dst_addr      = da;
    h.src_port      = sp;
    h.dst_port      = dp;
    h.total_length  = tot;
    h.ip_hdr_words  = ihl;
    h.tcp_hdr_words = doff;
    h.fin           = fin;
    h.now_tick      = now;
    return h;
  endfunction

  function automatic verdict_t vd(logic a, logic [FlowSlotW-1:0] s, logic c,
                                  logic [31:0] ab, logic [31:0] db);
    verdict_t v;
    v.accept     = a;
    v.slot       = s;
    v.created    = c;
    v.acc_bytes  = ab;
    v.drop_bytes = db;
    return v;
  endfunction

  function automatic void add_item(hdr_t h);
    dir_row_t r;
    r.kind  = RowHeader;
    r.idx   = '0;
    r.val   = '0;
    r.hdr   = h;
    r.typed = 1'b0;
    r.want  = vd(1'b0, '0, 1'b0, '0, '0);
    dir_rows.push_back(r);
  endfunction

  function automatic void add_typed(hdr_t h, verdict_t w);
    dir_row_t r;
    r.kind  = RowHeader;
    r.idx   = '0;
    r.val   = '0;
    r.hdr   = h;
    r.typed = 1'b1;
    r.want  = w;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    dir_row_t r;
    r.kind  = RowRegWrite;
    r.idx   = idx;
    r.val   = val;
    r.hdr   = mk_hdr(1'b0, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0);
    r.typed = 1'b0;
    r.want  = vd(1'b0, '0, 1'b0, '0, '0);
    dir_rows.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted)
      $display("mismatch in %s at verdict %0d: got 0x%08h, want 0x%08h",
               field, result_count, got, want);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    s_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_header(hdr_t h, bit typed, verdict_t want);
    int       gap;
    verdict_t v;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_data  = {h.now_tick, h.tcp_hdr_words, h.ip_hdr_words, h.total_length,
               h.dst_port, h.src_port, h.dst_addr, h.src_addr};
    s_tcp   = h.is_tcp;
    s_fin   = h.fin;
    do @(posedge clk_i); while (!s_ready);
    v = police_header(h);
    verdict_q.push_back(typed ? want : v);
    sent_count++;
    if (h.is_tcp) tcp_count++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    release_input();
    wait_drained();
    repeat (DrainPad) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(posedge clk_i);
    case (idx)
      CfgThreshold: thr_reg = 32'(val);
      CfgRate:      rate_reg = 32'(val);
      CfgMsPerTick: ms_reg = 32'(val[MsW-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  always @(posedge clk_i) begin : verdict_check
    verdict_t w;
    if (rst_ni && m_valid && m_ready) begin
      result_count++;
      if (verdict_q.size() == 0) begin
        report_mismatch("verdict word with nothing pending", m_data[31:0], '0);
      end else begin
        w = verdict_q.pop_front();
        if (m_data[0] !== w.accept) report_mismatch("accept", 32'(m_data[0]), 32'(w.accept));
        if (m_data[12:1] !== w.slot) report_mismatch("flow_slot", 32'(m_data[12:1]), 32'(w.slot));
        if (m_data[13] !== w.created)
          report_mismatch("flow_created", 32'(m_data[13]), 32'(w.created));
        if (m_data[45:14] !== w.acc_bytes)
          report_mismatch("flow_accepted_bytes", m_data[45:14], w.acc_bytes);
        if (m_data[77:46] !== w.drop_bytes)
          report_mismatch("flow_dropped_bytes", m_data[77:46], w.drop_bytes);
        if (!w.accept) dropped_verdicts++;
        if (w.created) create_count++;
      end
    end
  end

  initial begin : drain_side
    int stall;
    m_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
        m_ready  = 1'b1;
      end else begin
        stall = (no_idle || $urandom_range(3) != 0) ? 0 : pick_gap();
        if (stall > 0) begin
          m_ready = 1'b0;
          repeat (stall) @(negedge clk_i);
        end
        m_ready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d verdicts pending", verdict_q.size());
    $display("per_flow_byte_rate_policer verification failed");
    $finish;
  end

  initial begin : stimulus
    hdr_t        h;
    verdict_t    none;
    logic [31:0] pool_sa [PoolSize];
    logic [31:0] pool_da [PoolSize];
    logic [15:0] pool_sp [PoolSize];
    logic [15:0] pool_dp [PoolSize];
    logic [31:0] tick;
    int          hdr_bytes;
    int          pick;
    int          r;

    rst_ni   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    s_valid  = 1'b0;
    s_data   = '0;
    s_tcp    = 1'b0;
    s_fin    = 1'b0;
    none     = vd(1'b0, '0, 1'b0, '0, '0);
    thr_reg  = 32'(ThrReset);
    rate_reg = 32'(RateReset);
    ms_reg   = 32'(MsReset);
    foreach (flow_tab[i]) flow_tab[i].valid = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // default registers: non-tcp, payload edge cases, fin teardown
    add_typed(mk_hdr(1'b0, '1, '1, '1, '1, '1, '1, '1, 1'b1, '1), vd(1'b1, 0, 1'b0, 0, 0));
    add_typed(mk_hdr(1'b0, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0), vd(1'b1, 0, 1'b0, 0, 0));
    add_typed(mk_hdr(1'b1, '0, '0, '0, '0, 16'd100, 4'd5, 4'd5, 1'b0, '0),
              vd(1'b1, 1, 1'b1, 60, 0));
    add_typed(mk_hdr(1'b1, '0, '0, '0, '0, 16'd40, 4'd5, 4'd5, 1'b0, 32'd3),
              vd(1'b1, 1, 1'b0, 60, 0));
    add_typed(mk_hdr(1'b1, '0, '0, '0, '0, 16'd0, 4'd15, 4'd15, 1'b0, 32'd4),
              vd(1'b1, 1, 1'b0, 60, 0));
    add_typed(mk_hdr(1'b1, '0, '0, '0, '0, 16'd140, 4'd5, 4'd5, 1'b1, 32'd5),
              vd(1'b1, 1, 1'b0, 160, 0));
    add_typed(mk_hdr(1'b1, '0, '0, '0, '0, 16'd100, 4'd5, 4'd5, 1'b0, 32'd6),
              vd(1'b1, 1, 1'b1, 60, 0));
    add_typed(mk_hdr(1'b1, '1, '1, '1, '1, '1, 4'd0, 4'd0, 1'b1, '1),
              vd(1'b1, 0, 1'b1, 65535, 0));
    // small threshold, first refill, time backward and far ahead
    add_reg(CfgThreshold, 31'd1000);
    add_reg(CfgRate, 31'd100);
    add_reg(CfgMsPerTick, 31'h7FFF_FFE8);
    add_reg(CfgSpare, 31'h7FFF_FFFF);
    add_item(mk_hdr(1'b1, 32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80, 16'd2040,
                    4'd5, 4'd5, 1'b0, 32'd5));
    add_item(mk_hdr(1'b1, 32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80, 16'd140,
                    4'd5, 4'd5, 1'b0, 32'd10));
    add_item(mk_hdr(1'b1, 32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80, 16'd140,
                    4'd5, 4'd5, 1'b0, 32'd12));
    add_item(mk_hdr(1'b1, 32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80, 16'd140,
                    4'd5, 4'd5, 1'b0, 32'd8));
    add_item(mk_hdr(1'b1, 32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80, 16'd140,
                    4'd5, 4'd5, 1'b0, 32'h8000_0010));
    add_item(mk_hdr(1'b1, 32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80, 16'd40,
                    4'd5, 4'd5, 1'b1, 32'd20));
    // zero threshold drops everything, then register extremes
    add_reg(CfgThreshold, 31'd0);
    add_item(mk_hdr(1'b1, 32'hC0A8_0001, 32'hC0A8_0002, 16'd40000, 16'd443, 16'd100,
                    4'd5, 4'd5, 1'b0, 32'd50));
    add_reg(CfgThreshold, 31'h7FFF_FFFF);
    add_reg(CfgRate, 31'h7FFF_FFFF);
    add_reg(CfgMsPerTick, 31'd0);
    add_item(mk_hdr(1'b1, 32'hC0A8_0001, 32'hC0A8_0002, 16'd40000, 16'd443, 16'd1500,
                    4'd5, 4'd5, 1'b0, 32'd100));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowRegWrite) write_reg(dir_rows[i].idx, dir_rows[i].val);
      else send_header(dir_rows[i].hdr, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CfgThreshold, 31'd4000);
          write_reg(CfgRate, 31'd1);
          write_reg(CfgMsPerTick, 31'd1);
        end
        1: begin
          write_reg(CfgThreshold, 31'd20000);
          write_reg(CfgRate, 31'($urandom_range(0, 200)));
          write_reg(CfgMsPerTick, {21'($urandom), MsW'($urandom_range(1, 1000))});
        end
        2: begin
          write_reg(CfgThreshold, 31'd0);
          write_reg(CfgRate, 31'd0);
          write_reg(CfgMsPerTick, 31'd1000);
        end
        3: begin
          write_reg(CfgThreshold, 31'h7FFF_FFFF);
          write_reg(CfgRate, 31'h7FFF_FFFF);
          write_reg(CfgMsPerTick, 31'd1000);
        end
        4: begin
          write_reg(CfgThreshold, 31'($urandom_range(0, 30000)));
          write_reg(CfgRate, 31'h7FFF_FFFF);
          write_reg(CfgMsPerTick, {21'($urandom), MsW'($urandom_range(1, 1000))});
        end
        default: begin
          write_reg(CfgThreshold, 31'($urandom_range(500, 8000)));
          write_reg(CfgRate, 31'($urandom_range(0, 5000)));
          write_reg(CfgMsPerTick, {21'($urandom), MsW'($urandom_range(1, 1000))});
        end
      endcase

      // second half of the pool mirrors the first, same slot by construction
      for (int i = 0; i < PoolSize / 2; i++) begin
        pool_sa[i] = $urandom;
        pool_da[i] = $urandom;
        pool_sp[i] = 16'($urandom);
        pool_dp[i] = 16'($urandom);
        pool_sa[i + PoolSize / 2] = pool_da[i];
        pool_da[i + PoolSize / 2] = pool_sa[i];
        pool_sp[i + PoolSize / 2] = pool_dp[i];
        pool_dp[i + PoolSize / 2] = pool_sp[i];
      end
      tick    = $urandom;
      no_idle = (ph == 2);

      for (int k = 0; k < PhaseWords; k++) begin
        if (ph == 1 && k == 20) hold_req = 1'b1;
        if (ph == 3 && k == 40) begin
          release_input();
          wait_drained();
        end
        r = $urandom_range(99);
        if (r < 3) tick = $urandom;
        else if (r < 6) tick = tick - $urandom_range(1, 50);
        else tick = tick + $urandom_range(0, 6);

        pick     = $urandom_range(PoolSize + 1);
        h.is_tcp = ($urandom_range(7) != 0);
        if (pick < PoolSize) begin
          h.src_addr = pool_sa[pick];
          h.dst_addr = pool_da[pick];
          h.src_port = pool_sp[pick];
          h.dst_port = pool_dp[pick];
        end else begin
          h.src_addr = $urandom;
          h.dst_addr = $urandom;
          h.src_port = 16'($urandom);
          h.dst_port = 16'($urandom);
        end
        if ($urandom_range(9) < 8) begin
          h.ip_hdr_words  = 4'd5;
          h.tcp_hdr_words = 4'($urandom_range(5, 15));
        end else begin
          h.ip_hdr_words  = 4'($urandom);
          h.tcp_hdr_words = 4'($urandom);
        end
        hdr_bytes = 4 * (int'(h.ip_hdr_words) + int'(h.tcp_hdr_words));
        r = $urandom_range(99);
        if (r < 75) h.total_length = 16'(hdr_bytes + $urandom_range(0, 1460));
        else if (r < 88) h.total_length = 16'($urandom);
        else h.total_length = 16'($urandom_range(0, hdr_bytes));
        h.fin      = ($urandom_range(24) == 0);
        h.now_tick = tick;
        send_header(h, 1'b0, none);
      end
    end

    release_input();
    wait_drained();
    repeat (DrainPad) @(posedge clk_i);
    $display("covered %0d header words (%0d tcp) over six register phases and a directed list",
             sent_count, tcp_count);
    $display("verdicts checked %0d: %0d drops, %0d flow creations, %0d mismatches",
             result_count, dropped_verdicts, create_count, mismatch_count);
    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("per_flow_byte_rate_policer verification clean");
    end else begin
      $display("per_flow_byte_rate_policer verification failed");
    end
    $finish;
  end

endmodule
